// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the sorted key table (used by sorted_key_table_core.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SKT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SKT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/skt_pkg.sv =====
// Package for the sorted key table: sizes, codes and cell interface types.
`timescale 1ns / 1ps

package skt_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int STAT_W   = 3;
   localparam int MODE_W   = 2;
   localparam int OCNT_W   = 5;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_INSERT,
      UPD_REMOVE
   } upd_op_type;

   // One entry as held by a cell.
   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        value;
   } entry_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                    cmp;
      logic signed [KEY_W-1:0] cmp_key;
      upd_op_type              op;
      logic signed [KEY_W-1:0] ins_key;
      logic [VAL_W-1:0]        ins_value;
   } ctl_type;

endpackage

// ===== sv/skt_cell.sv =====
// One compare-and-shift cell of the sorted key table.
`timescale 1ns / 1ps

module skt_cell
   import skt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ctl_type          ctl,
   input  entry_type        left_entry,   // neighbor toward the smaller keys
   input  logic             left_lt,
   input  entry_type        right_entry,  // neighbor toward the larger keys
   output entry_type        entry,
   output logic             lt,
   output logic             eq,
   output logic [VAL_W-1:0] hit_value
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             lt_ff, eq_ff;
   logic [VAL_W-1:0] hit_value_ff;
   logic             cmp_lt, cmp_eq;

   assign cmp_lt = valid_ff && ($signed(key_ff) < ctl.cmp_key);
   assign cmp_eq = valid_ff && ($signed(key_ff) == ctl.cmp_key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      case (ctl.op)
         UPD_INSERT: begin
            if (!lt_ff) begin
               if (left_lt) begin
                  // first slot not below the new key: take the new entry
                  valid_in = 1'b1;
                  key_in   = ctl.ins_key;
                  value_in = ctl.ins_value;
               end else begin
                  valid_in = left_entry.valid;
                  key_in   = left_entry.key;
                  value_in = left_entry.value;
               end
            end
         end
         UPD_REMOVE: begin
            if (!lt_ff) begin
               valid_in = right_entry.valid;
               key_in   = right_entry.key;
               value_in = right_entry.value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
      if (ctl.cmp) begin
         lt_ff        <= cmp_lt;
         eq_ff        <= cmp_eq;
         hit_value_ff <= cmp_eq ? value_ff : '0;
      end
   end

   assign entry.valid = valid_ff;
   assign entry.key   = $signed(key_ff);
   assign entry.value = value_ff;
   assign lt          = lt_ff;
   assign eq          = eq_ff;
   assign hit_value   = hit_value_ff;

endmodule

// ===== sv/sorted_key_table_core.sv =====
// Top level of the sorted key table: controller, cell chain and result register.
// A request is compared in the cell chain as it is accepted; the update state then shifts the chain.
// No new request is taken while the chain is in the update state (the compare-then-shift pass).
// A response still waiting for rsp_tready holds off the next request; both beats may share an edge.
// Reset (synchronous, active high) empties the table, clears the count and drops rsp_tvalid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_key_table_core
   import skt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // mode[1:0], key[33:2], value[65:34], zero pad[71:66]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[2:0], found_value[34:3], count[39:35]
);

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [MODE_W-1:0]       mode_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0]        value_ff;
   logic                    rsp_valid_ff;
   logic [STAT_W-1:0]       status_ff, status_in;
   logic [VAL_W-1:0]        found_ff, found_in;
   logic [OCNT_W-1:0]       rsp_count_ff;

   logic                    req_beat;
   logic                    hit, full, empty;
   logic [VAL_W-1:0]        hit_value;
   ctl_type                 ctl;
   upd_op_type              op;
   logic [31:0]             count_wide;

   entry_type               cell_entry [CAPACITY];
   logic [CAPACITY-1:0]     cell_lt;
   logic [CAPACITY-1:0]     cell_eq;
   logic [VAL_W-1:0]        cell_hit_value [CAPACITY];
   logic [CAPACITY-1:0]     valid_vec;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_beat   = req_tvalid && req_tready;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // eq is one-hot at most since keys are unique; OR the masked values together
   always_comb begin
      hit       = 1'b0;
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit       = hit | cell_eq[i];
         hit_value = hit_value | cell_hit_value[i];
      end
   end

   // decide the chain operation and the response in the update cycle
   always_comb begin
      op        = UPD_NONE;
      status_in = ST_OK;
      found_in  = '0;
      count_in  = count_ff;
      case (mode_ff)
         MODE_INSERT: begin
            if (hit) begin
               status_in = ST_DUPLICATE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               op       = UPD_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_REMOVE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!hit) begin
               status_in = ST_NOT_FOUND;
            end else begin
               op       = UPD_REMOVE;
               found_in = hit_value;
               count_in = count_ff - CNT_W'(1);
            end
         end
         MODE_SEARCH: begin
            if (hit) begin
               found_in = hit_value;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            // unused mode: no operation
         end
      endcase
   end

   assign count_wide = 32'(count_in);

   assign ctl.cmp       = req_beat;
   assign ctl.cmp_key   = $signed(req_tdata[33:2]);
   assign ctl.op        = (state_ff == S_UPDATE) ? op : UPD_NONE;
   assign ctl.ins_key   = key_ff;
   assign ctl.ins_value = value_ff;

   // cell chain: cell 0 holds the smallest key
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_lt;

      if (g == 0) begin : g_first
         assign left_entry = '0;
         assign left_lt    = 1'b1;
      end else begin : g_inner_left
         assign left_entry = cell_entry[g-1];
         assign left_lt    = cell_lt[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner_right
         assign right_entry = cell_entry[g+1];
      end

      skt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .entry       (cell_entry[g]),
         .lt          (cell_lt[g]),
         .eq          (cell_eq[g]),
         .hit_value   (cell_hit_value[g])
      );

      assign valid_vec[g] = cell_entry[g].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               state_ff     <= S_IDLE;
               count_ff     <= count_in;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      // request and response payload, no reset
      if (req_beat) begin
         mode_ff  <= req_tdata[1:0];
         key_ff   <= $signed(req_tdata[33:2]);
         value_ff <= req_tdata[65:34];
      end
      if (state_ff == S_UPDATE) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         rsp_count_ff <= count_wide[OCNT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, found_ff, status_ff};

   // an accepted request raises rsp_tvalid once the update state is over
   `SKT_ASSERT(a_rsp_two_cycles, clock, reset, req_beat |=> ##1 rsp_tvalid, "response not produced two cycles after request")
   // no new request while the chain is updating
   `SKT_ASSERT(a_no_overlap, clock, reset, req_beat |=> !req_tready, "request accepted during update")
   // valid bits always match the entry count
   `SKT_ASSERT(a_count_matches, clock, reset, $countones(valid_vec) == int'(count_ff), "valid bits disagree with count")
   // count never passes the capacity
   `SKT_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")

endmodule

// ===== tb/tb_sorted_key_table_core.sv =====
// Self-checking testbench for sorted_key_table_core: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_sorted_key_table_core;
   import skt_pkg::*;

   localparam realtime CLK_PERIOD   = 12.0;
   localparam int      RANDOM_ITEMS = 1080;
   localparam int      POOL_SIZE    = 20;
   localparam int      DIR_ROWS     = 22;
   // Mode 3 is not an operation: the block answers ok and changes nothing.
   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;

   // One response, status in the top bits; the response side unpacks rsp_tdata into it.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  found_value;
      logic [OCNT_W-1:0] count;
   } table_result_type;

   // Row of the directed table; reps > 1 repeats the row with key and value stepped by one.
   typedef struct {
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        value;
      int                      reps;
      bit                      typed;
      table_result_type        want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // mode[1:0], key[33:2], value[65:34], zero pad[71:66]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // status[2:0], found_value[34:3], count[39:35]

   // Mirror of the table contents, kept packed in ascending signed key order.
   logic signed [KEY_W-1:0] mirror_keys   [CAPACITY];
   logic [VAL_W-1:0]        mirror_values [CAPACITY];
   int                      mirror_count;

   table_result_type        awaited_results[$];
   logic signed [KEY_W-1:0] key_pool[POOL_SIZE];
   plan_row_type            plan[DIR_ROWS];

   bit req_burst;
   bit rsp_burst;
   int mismatches;
   int mode_tally[4];
   int status_tally[8];

   sorted_key_table_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2.0) clock = ~clock;
   end

   // Applies one request to the mirror and returns the response it must produce.
   function automatic table_result_type table_apply(input logic [MODE_W-1:0] mode,
                                                    input logic signed [KEY_W-1:0] key,
                                                    input logic [VAL_W-1:0] value);
      table_result_type res;
      int               slot;
      int               i;
      bit               hit;
      res  = '0;
      slot = 0;
      // first slot whose key is not below the request key
      while (slot < mirror_count && mirror_keys[slot] < key) slot++;
      hit = (slot < mirror_count) && (mirror_keys[slot] == key);
      case (mode)
         MODE_INSERT: begin
            // duplicate check wins over the full check
            if (hit) begin
               res.status = ST_DUPLICATE;
            end else if (mirror_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (i = mirror_count; i > slot; i--) begin
                  mirror_keys[i]   = mirror_keys[i-1];
                  mirror_values[i] = mirror_values[i-1];
               end
               mirror_keys[slot]   = key;
               mirror_values[slot] = value;
               mirror_count++;
            end
         end
         MODE_REMOVE: begin
            if (mirror_count == 0) begin
               res.status = ST_EMPTY;
            end else if (!hit) begin
               res.status = ST_NOT_FOUND;
            end else begin
               res.found_value = mirror_values[slot];
               for (i = slot; i + 1 < mirror_count; i++) begin
                  mirror_keys[i]   = mirror_keys[i+1];
                  mirror_values[i] = mirror_values[i+1];
               end
               mirror_count--;
            end
         end
         MODE_SEARCH: begin
            if (hit) res.found_value = mirror_values[slot];
            else res.status = ST_NOT_FOUND;
         end
         default: begin
         end
      endcase
      res.count = mirror_count[OCNT_W-1:0];
      return res;
   endfunction

   // Key choice for random traffic: often a stored key, else the phase pool, else anything.
   function automatic logic signed [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40 && mirror_count > 0) return mirror_keys[$urandom_range(0, mirror_count - 1)];
      if (roll < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // Presents one request beat and waits for it to be taken. The expectation is the typed
   // one when given, else the mirror's; the mirror is updated either way.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic signed [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value,
                               input bit typed,
                               input table_result_type want);
      int               gap;
      table_result_type predicted;
      gap = req_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, value, key, mode};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = table_apply(mode, key, value);
      awaited_results.push_back(typed ? want : predicted);
      mode_tally[mode]++;
   endtask

   // Holds the sender back until every response in flight has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // Response side: random stall before each beat, then compare with the oldest expectation.
   initial begin : response_side
      int               stall;
      table_result_type got;
      table_result_type want;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got = {rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[39:35]};
         status_tally[got.status]++;
         if (awaited_results.size() == 0) begin
            $error("response beat with no request outstanding: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               mismatches++;
            end
            if (got.found_value !== want.found_value) begin
               $error("found_value: expected %h, got %h", want.found_value, got.found_value);
               mismatches++;
            end
            if (got.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, got.count);
               mismatches++;
            end
         end
      end
   end

   // Run limit: far above the slowest legal run (every beat waiting out both stalls).
   initial begin : watchdog
      #(400_000 * CLK_PERIOD);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int            row;
      int            rep;
      int            sent;
      int            phase_len;
      int            phase_kind;
      int            roll;
      int            n;
      int            p;
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        value;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_burst  = 1'b0;
      rsp_burst  = 1'b0;
      mismatches = 0;
      mirror_count = 0;
      foreach (mode_tally[i]) mode_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;

      // Empty-table cases, extremes of key and value, duplicate, fill to full,
      // insert into a full table (and a duplicate there), then take the extremes back out.
      plan = '{
         '{MODE_SEARCH, 32'sh0000_0000, 32'h0000_0000,  1, 1'b1, {ST_NOT_FOUND, 32'h0, 5'd0}},
         '{MODE_REMOVE, 32'sh0000_0000, 32'h0000_0000,  1, 1'b1, {ST_EMPTY, 32'h0, 5'd0}},
         '{MODE_IDLE,   32'sh7fff_ffff, 32'hffff_ffff,  1, 1'b1, {ST_OK, 32'h0, 5'd0}},
         '{MODE_INSERT, 32'sh8000_0000, 32'hffff_ffff,  1, 1'b1, {ST_OK, 32'h0, 5'd1}},
         '{MODE_INSERT, 32'sh7fff_ffff, 32'h0000_0000,  1, 1'b1, {ST_OK, 32'h0, 5'd2}},
         '{MODE_INSERT, 32'sh0000_0000, 32'ha5a5_a5a5,  1, 1'b1, {ST_OK, 32'h0, 5'd3}},
         '{MODE_INSERT, 32'shffff_ffff, 32'h5a5a_5a5a,  1, 1'b1, {ST_OK, 32'h0, 5'd4}},
         '{MODE_INSERT, 32'sh0000_0000, 32'h0000_0001,  1, 1'b1, {ST_DUPLICATE, 32'h0, 5'd4}},
         '{MODE_INSERT, 32'sh0000_0001, 32'h0000_1000, 12, 1'b0, '0},
         '{MODE_INSERT, 32'sh0000_0064, 32'hdead_0001,  1, 1'b1, {ST_FULL, 32'h0, 5'd16}},
         '{MODE_INSERT, 32'sh0000_0000, 32'hdead_0002,  1, 1'b1, {ST_DUPLICATE, 32'h0, 5'd16}},
         '{MODE_SEARCH, 32'sh7fff_ffff, 32'h0000_0000,  1, 1'b1, {ST_OK, 32'h0, 5'd16}},
         '{MODE_SEARCH, 32'sh8000_0000, 32'h0000_0000,  1, 1'b1, {ST_OK, 32'hffff_ffff, 5'd16}},
         '{MODE_SEARCH, 32'sh0000_000d, 32'h0000_0000,  1, 1'b1, {ST_NOT_FOUND, 32'h0, 5'd16}},
         '{MODE_REMOVE, 32'sh0000_000d, 32'h0000_0000,  1, 1'b1, {ST_NOT_FOUND, 32'h0, 5'd16}},
         '{MODE_IDLE,   32'sh0000_0000, 32'h1234_5678,  1, 1'b1, {ST_OK, 32'h0, 5'd16}},
         '{MODE_REMOVE, 32'shffff_ffff, 32'h0000_0000,  1, 1'b1, {ST_OK, 32'h5a5a_5a5a, 5'd15}},
         '{MODE_REMOVE, 32'sh8000_0000, 32'h0000_0000,  1, 1'b1, {ST_OK, 32'hffff_ffff, 5'd14}},
         '{MODE_REMOVE, 32'sh7fff_ffff, 32'h0000_0000,  1, 1'b1, {ST_OK, 32'h0, 5'd13}},
         '{MODE_REMOVE, 32'sh0000_0000, 32'h0000_0000,  1, 1'b1, {ST_OK, 32'ha5a5_a5a5, 5'd12}},
         '{MODE_SEARCH, 32'sh0000_0007, 32'h0000_0000,  1, 1'b0, '0},
         '{MODE_REMOVE, 32'sh0000_000c, 32'h0000_0000,  1, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIR_ROWS; row++) begin
         for (rep = 0; rep < plan[row].reps; rep++) begin
            send_request(plan[row].mode, plan[row].key + rep, plan[row].value + rep,
                         plan[row].typed, plan[row].want);
         end
      end
      drain_responses();

      // Random part in phases: filling, draining and mixed, so the table swings between
      // empty and full many times. Keys come mostly from stored entries and a small pool.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_kind = $urandom_range(0, 2);
         phase_len  = $urandom_range(40, 120);
         req_burst  = ($urandom_range(0, 3) == 0);
         rsp_burst  = ($urandom_range(0, 3) == 0);
         for (p = 0; p < POOL_SIZE; p++) key_pool[p] = $urandom;
         key_pool[0] = 32'sh8000_0000;
         key_pool[1] = 32'sh7fff_ffff;
         for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            case (phase_kind)
               0:       mode = (roll < 65) ? MODE_INSERT : (roll < 80) ? MODE_REMOVE :
                               (roll < 97) ? MODE_SEARCH : MODE_IDLE;
               1:       mode = (roll < 20) ? MODE_INSERT : (roll < 65) ? MODE_REMOVE :
                               (roll < 97) ? MODE_SEARCH : MODE_IDLE;
               default: mode = (roll < 35) ? MODE_INSERT : (roll < 70) ? MODE_REMOVE :
                               (roll < 97) ? MODE_SEARCH : MODE_IDLE;
            endcase
            key = pick_key();
            roll = $urandom_range(0, 9);
            value = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hffff_ffff : $urandom;
            send_request(mode, key, value, 1'b0, '0);
            sent++;
         end
         if ($urandom_range(0, 2) == 0) drain_responses();
      end

      drain_responses();
      // keep the clock running so a stray extra beat would still be caught
      repeat (8) @(posedge clock);

      $display("Requests: %0d inserts, %0d removes, %0d searches, %0d no-ops.",
               mode_tally[MODE_INSERT], mode_tally[MODE_REMOVE],
               mode_tally[MODE_SEARCH], mode_tally[MODE_IDLE]);
      $display("Responses: %0d ok, %0d duplicate, %0d full, %0d empty, %0d missing key.",
               status_tally[ST_OK], status_tally[ST_DUPLICATE], status_tally[ST_FULL],
               status_tally[ST_EMPTY], status_tally[ST_NOT_FOUND]);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/skt_pkg.sv
sv/skt_cell.sv
sv/sorted_key_table_core.sv
tb/tb_sorted_key_table_core.sv
